@@ rtl/hfeb_pkg.sv @@
package hfeb_pkg;
   localparam int NodeBitsDef  = 16;
   localparam int LevelsDef    = 3;
   localparam int MaxWantedDef = 16;
   localparam int ExtW         = 12;
   localparam int WantW        = 5;
   localparam int FuncW        = 2;
   localparam int ResultLimit  = 16;

   typedef enum logic [FuncW-1:0] {
      FUNC_MARK_FULL = 2'd0,
      FUNC_MARK_FREE = 2'd1,
      FUNC_FIND      = 2'd2,
      FUNC_NOP       = 2'd3
   } func_type;

   // words in a subtree whose root is at level k
   function automatic longint sub_words(input int nb, input int k);
      longint s;
      longint p;
      s = 0;
      p = 1;
      for (int i = 0; i <= k; i++) begin
         s = s + p;
         p = p * nb;
      end
      return s;
   endfunction

   function automatic longint pow_nb(input int nb, input int k);
      longint p;
      p = 1;
      for (int i = 0; i < k; i++) begin
         p = p * nb;
      end
      return p;
   endfunction
endpackage

@@ rtl/hfeb_req_if.sv @@
interface hfeb_req_if;
   import hfeb_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [FuncW-1:0]       func;
   logic [ExtW-1:0]        target_ext;
   logic [WantW-1:0]       wanted_count;
   modport source (output valid, func, target_ext, wanted_count, input ready);
   modport sink   (input valid, func, target_ext, wanted_count, output ready);
endinterface

@@ rtl/hfeb_rsp_if.sv @@
interface hfeb_rsp_if;
   import hfeb_pkg::*;
   logic            valid;
   logic            ready;
   logic [ExtW-1:0] found_extent;
   logic            found;
   logic            last;
   modport source (output valid, found_extent, found, last, input ready);
   modport sink   (input valid, found_extent, found, last, output ready);
endinterface

@@ rtl/hierarchical_free_extent_bitmap.sv @@
// Mark: read, wait and write back per level on the node memory, leaf first, then
//   parents bottom up; no-op and out of range answer with an empty final result.
// Find: per node word a read, a wait and a scan of its child bits.
// Output stalls hold both; results leave through a one-entry output register.
// Reset (synchronous, active high): a clearing pass writes zero to every node
//   word, with req.ready low.
module hierarchical_free_extent_bitmap
   import hfeb_pkg::*;
#(
   parameter int NODE_BITS  = NodeBitsDef,
   parameter int LEVELS     = LevelsDef,
   parameter int MAX_WANTED = MaxWantedDef
) (
   input logic clock,
   input logic reset,
   hfeb_req_if.sink   req,
   hfeb_rsp_if.source rsp
);
   localparam longint NodeCountL = sub_words(NODE_BITS, LEVELS - 1);
   localparam int     NodeCount  = int'(NodeCountL);
   localparam int     AddrW      = (NodeCount > 1) ? $clog2(NodeCount) : 1;
   localparam longint ExtCountL  = pow_nb(NODE_BITS, LEVELS);
   localparam int     BitW       = (NODE_BITS > 1) ? $clog2(NODE_BITS) : 1;
   localparam int     LvW        = (LEVELS > 1) ? $clog2(LEVELS) : 1;
   localparam int     CapLim     = (MAX_WANTED < ResultLimit) ? MAX_WANTED : ResultLimit;
   localparam int     EW         = 32;

   // rounded-up reciprocals of NODE_BITS**k, exact for any ExtW-bit extent number
   localparam int     QuoSh      = 2 * ExtW;
   localparam longint QuoOne     = longint'(1) << QuoSh;
   localparam longint Pow1       = pow_nb(NODE_BITS, 1);
   localparam longint Pow2       = pow_nb(NODE_BITS, 2);
   localparam longint Pow3       = pow_nb(NODE_BITS, 3);
   localparam longint Pow4       = pow_nb(NODE_BITS, 4);
   localparam longint Pow5       = pow_nb(NODE_BITS, 5);
   localparam longint Recip1     = (QuoOne + Pow1 - 1) / Pow1;
   localparam longint Recip2     = (QuoOne + Pow2 - 1) / Pow2;
   localparam longint Recip3     = (QuoOne + Pow3 - 1) / Pow3;
   localparam longint Recip4     = (QuoOne + Pow4 - 1) / Pow4;
   localparam longint Recip5     = (QuoOne + Pow5 - 1) / Pow5;

   typedef enum logic [9:0] {
      S_CLEAR = 10'b0000000001,
      S_IDLE  = 10'b0000000010,
      S_MRD   = 10'b0000000100,
      S_MWT   = 10'b0000001000,
      S_MWR   = 10'b0000010000,
      S_FRD   = 10'b0000100000,
      S_FWT   = 10'b0001000000,
      S_FSCAN = 10'b0010000000,
      S_OUT   = 10'b0100000000,
      S_ACK   = 10'b1000000000
   } state_type;

   logic [NODE_BITS-1:0] mem [NodeCount];
   logic [NODE_BITS-1:0] rd_data_ff;

   state_type            state_ff, state_in;
   logic [AddrW-1:0]     clr_ff, clr_in;
   logic                 full_ff, full_in;
   logic [EW-1:0]        ext_ff, ext_in;
   logic [LvW-1:0]       lv_ff, lv_in;
   logic                 prev_full_ff, prev_full_in;
   logic [4:0]           cap_ff, cap_in;
   logic [4:0]           n_ff, n_in;
   logic                 pend_ff, pend_in;
   logic [ExtW-1:0]      pend_ext_ff, pend_ext_in;
   // walk stack, one entry per level
   logic [AddrW-1:0]     pg_ff [LEVELS], pg_in [LEVELS];
   logic [EW-1:0]        base_ff [LEVELS], base_in [LEVELS];
   logic [BitW:0]        c_ff [LEVELS], c_in [LEVELS];
   logic [NODE_BITS-1:0] w_ff [LEVELS], w_in [LEVELS];
   logic                 ov_ff, ov_in;
   logic [ExtW-1:0]      oext_ff, oext_in;
   logic                 ofound_ff, ofound_in, olast_ff, olast_in;

   logic                 mem_we;
   logic [AddrW-1:0]     mem_wa, mem_ra;
   logic [NODE_BITS-1:0] mem_wd;
   logic                 mem_re;

   // floor(e / NODE_BITS**k) by reciprocal multiplication
   function automatic longint ext_quo(input logic [ExtW-1:0] e, input int k);
      longint m;
      unique case (k)
         1: m = Recip1;
         2: m = Recip2;
         3: m = Recip3;
         4: m = Recip4;
         5: m = Recip5;
         default: m = QuoOne;
      endcase
      return (longint'(e) * m) >> QuoSh;
   endfunction

   function automatic logic [BitW-1:0] path_bit(input logic [EW-1:0] e, input int l);
      return BitW'(ext_quo(e[ExtW-1:0], l) -
                   longint'(NODE_BITS) * ext_quo(e[ExtW-1:0], l + 1));
   endfunction

   // address of the path node at level l for extent e (path_bit gives its bit index)
   function automatic logic [AddrW-1:0] path_page(input logic [EW-1:0] e, input int l);
      longint p;
      longint d;
      p = 0;
      for (int k = LEVELS - 1; k > l; k--) begin
         d = longint'(path_bit(e, k));
         p = p + 1 + d * sub_words(NODE_BITS, k - 1);
      end
      return AddrW'(p);
   endfunction

   logic [AddrW-1:0] cur_page;
   logic [BitW-1:0]  cur_bit;
   logic [BitW-1:0]  st_bit;
   always_comb begin
      cur_page = '0;
      cur_bit  = '0;
      for (int l = 0; l < LEVELS; l++) begin
         if (lv_ff == LvW'(l)) begin
            cur_page = path_page(ext_ff, l);
            cur_bit  = path_bit(ext_ff, l);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_wa] <= mem_wd;
      if (mem_re) rd_data_ff <= mem[mem_ra];
   end

   logic              rsp_free;
   logic [BitW:0]     cc;
   logic [NODE_BITS-1:0] cw;
   logic [EW-1:0]     cbase;
   logic [AddrW-1:0]  cpg;
   logic [EW-1:0]     cand;
   assign rsp_free = !ov_ff || rsp.ready;

   always_comb begin
      state_in = state_ff; clr_in = clr_ff; full_in = full_ff; ext_in = ext_ff;
      lv_in = lv_ff; prev_full_in = prev_full_ff; cap_in = cap_ff; n_in = n_ff;
      pend_in = pend_ff; pend_ext_in = pend_ext_ff;
      pg_in = pg_ff; base_in = base_ff; c_in = c_ff; w_in = w_ff;
      ov_in = ov_ff && !rsp.ready; oext_in = oext_ff; ofound_in = ofound_ff;
      olast_in = olast_ff;
      mem_we = 1'b0; mem_wa = '0; mem_wd = '0; mem_re = 1'b0; mem_ra = '0;
      cc = '0; cw = '0; cbase = '0; cpg = '0; cand = '0; st_bit = '0;
      for (int l = 0; l < LEVELS; l++) begin
         if (lv_ff == LvW'(l)) begin
            cc = c_ff[l]; cw = w_ff[l]; cbase = base_ff[l]; cpg = pg_ff[l];
         end
      end
      unique case (state_ff)
         S_CLEAR: begin
            mem_we = 1'b1; mem_wa = clr_ff;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == AddrW'(NodeCount - 1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req.valid) begin
               ext_in = EW'(req.target_ext);
               lv_in  = '0;
               unique case (func_type'(req.func))
                  FUNC_MARK_FULL, FUNC_MARK_FREE: begin
                     full_in = (req.func == FUNC_MARK_FULL);
                     state_in = (EW'(req.target_ext) < EW'(ExtCountL)) ? S_MRD : S_ACK;
                  end
                  FUNC_FIND: begin
                     cap_in = (req.wanted_count > 5'(CapLim)) ? 5'(CapLim)
                                                             : req.wanted_count;
                     n_in = '0; pend_in = 1'b0;
                     lv_in = LvW'(LEVELS - 1);
                     pg_in[LEVELS-1] = '0;
                     base_in[LEVELS-1] = '0;
                     if (EW'(req.target_ext) < EW'(ExtCountL) && req.wanted_count != '0)
                        state_in = S_FRD;
                     else
                        state_in = S_ACK;
                  end
                  default: state_in = S_ACK;
               endcase
            end
         end
         S_MRD: begin
            mem_re = 1'b1; mem_ra = cur_page; state_in = S_MWT;
         end
         S_MWT: state_in = S_MWR;
         S_MWR: begin
            mem_we = 1'b1; mem_wa = cur_page; mem_wd = rd_data_ff;
            if (lv_ff == '0) mem_wd[cur_bit] = full_ff;
            else mem_wd[cur_bit] = prev_full_ff;
            prev_full_in = &mem_wd;
            if (lv_ff == LvW'(LEVELS - 1)) state_in = S_ACK;
            else begin
               lv_in = lv_ff + 1'b1; state_in = S_MRD;
            end
         end
         S_FRD: begin
            mem_re = 1'b1; mem_ra = cpg; state_in = S_FWT;
         end
         S_FWT: begin
            for (int l = 0; l < LEVELS; l++) begin
               if (lv_ff == LvW'(l)) begin
                  w_in[l] = rd_data_ff;
                  st_bit  = path_bit(ext_ff, l);
                  // start at the origin's bit only on the origin's own path, else at bit 0
                  c_in[l] = (ext_ff > base_ff[l]) ? {1'b0, st_bit} : '0;
               end
            end
            state_in = S_FSCAN;
         end
         S_FSCAN: begin
            if (cc >= (BitW+1)'(NODE_BITS)) begin
               if (lv_ff == LvW'(LEVELS - 1)) state_in = S_OUT;
               else lv_in = lv_ff + 1'b1;
            end else if (cw[cc[BitW-1:0]]) begin
               for (int l = 0; l < LEVELS; l++)
                  if (lv_ff == LvW'(l)) c_in[l] = cc + 1'b1;
            end else if (lv_ff == '0) begin
               // one free extent per cycle while the output register is free, held back one so last is known
               if (!pend_ff || rsp_free) begin
                  cand = cbase + EW'(cc);
                  if (pend_ff) begin
                     ov_in = 1'b1; oext_in = pend_ext_ff; ofound_in = 1'b1;
                     olast_in = 1'b0;
                  end
                  pend_in = 1'b1; pend_ext_in = cand[ExtW-1:0];
                  n_in = n_ff + 1'b1;
                  c_in[0] = cc + 1'b1;
                  if (n_ff + 1'b1 == cap_ff) state_in = S_OUT;
               end
            end else begin
               for (int l = 1; l < LEVELS; l++) begin
                  if (lv_ff == LvW'(l)) begin
                     c_in[l] = cc + 1'b1;
                     pg_in[l-1] = AddrW'(longint'(cpg) + 1 +
                                  longint'(cc) * sub_words(NODE_BITS, l - 1));
                     base_in[l-1] = cbase + EW'(longint'(cc) * pow_nb(NODE_BITS, l));
                  end
               end
               lv_in = lv_ff - 1'b1;
               state_in = S_FRD;
            end
         end
         S_OUT: begin
            if (rsp_free) begin
               ov_in = 1'b1; oext_in = pend_ff ? pend_ext_ff : '0;
               ofound_in = pend_ff; olast_in = 1'b1;
               pend_in = 1'b0; state_in = S_IDLE;
            end
         end
         S_ACK: begin
            if (rsp_free) begin
               ov_in = 1'b1; oext_in = '0; ofound_in = 1'b0; olast_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign req.ready = (state_ff == S_IDLE);
   assign rsp.valid = ov_ff;
   assign rsp.found_extent = oext_ff;
   assign rsp.found = ofound_ff;
   assign rsp.last = olast_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff   <= '0;
         ov_ff    <= 1'b0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         ov_ff    <= ov_in;
         pend_ff  <= pend_in;
      end
      full_ff <= full_in; ext_ff <= ext_in; lv_ff <= lv_in;
      prev_full_ff <= prev_full_in; cap_ff <= cap_in; n_ff <= n_in;
      pend_ext_ff <= pend_ext_in;
      pg_ff <= pg_in; base_ff <= base_in; c_ff <= c_in; w_ff <= w_in;
      oext_ff <= oext_in; ofound_ff <= ofound_in; olast_ff <= olast_in;
   end
endmodule

@@ rtl/hfeb_checker.sv @@
module hfeb_checker
   import hfeb_pkg::*;
(
   input logic            clock,
   input logic            reset,
   input logic            req_valid,
   input logic            req_ready,
   input logic            rsp_valid,
   input logic            rsp_ready,
   input logic [ExtW-1:0] rsp_found_extent,
   input logic            rsp_found,
   input logic            rsp_last
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_found_extent))
      else $error("rsp changed while stalled");
   a_ack_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_last && rsp_found_extent == '0)
      else $error("empty result not final or nonzero");
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("accepted back to back");
   a_rst: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result after reset");
endmodule

bind hierarchical_free_extent_bitmap hfeb_checker u_hfeb_checker (
   .clock(clock), .reset(reset),
   .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
   .rsp_found_extent(rsp.found_extent), .rsp_found(rsp.found), .rsp_last(rsp.last)
);
